### src/rafs_pkg.sv
// Shared definitions for the register allocator with FIFO spill.
// Holds operation codes, field widths and the pool control and status structs.
// No dependencies.
`default_nettype none

package rafs_pkg;

	// Default sizing of a register pool and of the stored variable identifier.
	localparam int NUM_REGS_DEF    = 32;
	localparam int VAR_ID_BITS_DEF = 16;

	// Fixed widths of the channel fields.
	localparam int OP_W   = 2;
	localparam int VAR_W  = 16;
	localparam int REG_W  = 5;
	localparam int MASK_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC    = 2'd0,
		OP_RESERVE  = 2'd1,
		OP_FREE_VAR = 2'd2,
		OP_FREE_REG = 2'd3
	} op_t;

	// Update command for one pool, applied at the clock edge.
	typedef struct packed {
		logic rm_var;    // remove the owner entry that matches the query variable
		logic rm_reg;    // remove the owner entry that matches the query register
		logic rm_head;   // remove the oldest owner entry
		logic append;    // append (query variable, target register) as the newest owner
		logic busy_clr;  // clear the busy bit of the target register
		logic busy_set;  // set the busy and used bits of the target register
	} pool_cmd_t;

	// Lookup status of one pool.
	typedef struct packed {
		logic var_hit;   // the query variable owns a register in this pool
		logic has_owner; // the owner list is not empty
	} pool_stat_t;

endpackage

`default_nettype wire

### src/rafs_req_if.sv
// Request channel of the register allocator: valid/ready handshake plus request fields.
// Depends on rafs_pkg for the field widths.
`default_nettype none

interface rafs_req_if;
	logic                        valid;
	logic                        ready;
	logic [rafs_pkg::OP_W-1:0]   op;
	logic                        reg_class;
	logic                        has_var;
	logic [rafs_pkg::VAR_W-1:0]  var_id;
	logic                        want_valid;
	logic [rafs_pkg::REG_W-1:0]  want_reg;

	modport source (
		output valid, op, reg_class, has_var, var_id, want_valid, want_reg,
		input  ready
	);
	modport sink (
		input  valid, op, reg_class, has_var, var_id, want_valid, want_reg,
		output ready
	);
endinterface

`default_nettype wire

### src/rafs_rsp_if.sv
// Response channel of the register allocator: valid/ready handshake plus result fields.
// Depends on rafs_pkg for the field widths.
`default_nettype none

interface rafs_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [rafs_pkg::REG_W-1:0]   reg_res;
	logic                         reg_valid;
	logic                         already_held;
	logic                         spilled;
	logic [rafs_pkg::VAR_W-1:0]   spilled_var;
	logic                         error;
	logic [rafs_pkg::MASK_W-1:0]  used_mask;

	modport source (
		output valid, reg_res, reg_valid, already_held, spilled, spilled_var, error,
		       used_mask,
		input  ready
	);
	modport sink (
		input  valid, reg_res, reg_valid, already_held, spilled, spilled_var, error,
		       used_mask,
		output ready
	);
endinterface

`default_nettype wire

### src/register_allocator_fifo_spill.sv
// Register allocator with FIFO spill: top level with the request and response stages.
// Depends on rafs_pkg, rafs_req_if, rafs_rsp_if and rafs_pool.
//
// Two register pools (integer and floating point) hand out registers to variables.
// A request passes through the request register and then the response register, from
// which its response transfers. One request is taken every clock cycle unless the
// response channel stalls.
// That rate is set by the combinational path from the request register through the
// owner match of both pools, the lowest-free priority encoder and the owner list
// compaction into the pool state, so each request sees every earlier one. A request
// moves on while its response register is empty or being drained in the same cycle.
// Reset empties both pools at once; there is no clearing pass.
`default_nettype none

module register_allocator_fifo_spill #(
	parameter int NUM_REGS    = rafs_pkg::NUM_REGS_DEF,
	parameter int VAR_ID_BITS = rafs_pkg::VAR_ID_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	rafs_req_if.sink   req,
	rafs_rsp_if.source rsp
);

	localparam int RW    = $clog2(NUM_REGS);
	localparam int VarW  = rafs_pkg::VAR_W;
	localparam int RegW  = rafs_pkg::REG_W;
	localparam int MaskW = rafs_pkg::MASK_W;

	// Request stage.
	logic                   v_s1;
	rafs_pkg::op_t          op_s1;
	logic                   cls_s1, hv_s1, wv_s1;
	logic [VAR_ID_BITS-1:0] var_s1;
	logic [RegW-1:0]        want_s1;

	// Response stage.
	logic             rsp_valid_q;
	logic [RegW-1:0]  reg_res_q;
	logic             reg_valid_q, held_q, spilled_q, error_q;
	logic [VarW-1:0]  spilled_var_q;
	logic [MaskW-1:0] used_mask_q;

	logic req_xfer, adv;

	// Pool interface.
	rafs_pkg::pool_cmd_t  cmd_sel;
	rafs_pkg::pool_cmd_t  cmd      [2];
	rafs_pkg::pool_stat_t stat     [2];
	logic [NUM_REGS-1:0]  busy     [2];
	logic [NUM_REGS-1:0]  used_nxt [2];
	logic [RW-1:0]        var_reg  [2];
	logic [RW-1:0]        head_reg [2];
	logic [VAR_ID_BITS-1:0] head_var [2];
	logic [RW-1:0]        tgt;

	// Decision signals.
	logic                   want_ok, want_free, any_free, held, evict, err;
	logic [RW-1:0]          want_idx, low_idx, regno, held_reg, grant;
	logic [NUM_REGS-1:0]    sb;
	rafs_pkg::pool_stat_t   ss;
	logic [RegW-1:0]        res_reg;
	logic                   res_valid, res_held, res_spilled, res_err;

	assign adv      = v_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !v_s1 || adv;
	assign req_xfer = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= req_xfer || (v_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_s1   <= rafs_pkg::op_t'(req.op);
			cls_s1  <= req.reg_class;
			hv_s1   <= req.has_var;
			var_s1  <= VAR_ID_BITS'(req.var_id);
			wv_s1   <= req.want_valid;
			want_s1 <= req.want_reg;
		end
	end

	for (genvar c = 0; c < 2; c++) begin : g_pool
		assign cmd[c] = (adv && cls_s1 == 1'(c)) ? cmd_sel : '0;

		rafs_pool #(
			.NUM_REGS    (NUM_REGS),
			.VAR_ID_BITS (VAR_ID_BITS)
		) u_pool (
			.clk      (clk),
			.arst_n   (arst_n),
			.qvar     (var_s1),
			.qreg     (want_idx),
			.tgt      (tgt),
			.cmd      (cmd[c]),
			.busy     (busy[c]),
			.used_nxt (used_nxt[c]),
			.stat     (stat[c]),
			.var_reg  (var_reg[c]),
			.head_reg (head_reg[c]),
			.head_var (head_var[c])
		);
	end

	assign sb       = busy[cls_s1];
	assign ss       = stat[cls_s1];
	assign want_ok  = 32'(want_s1) < NUM_REGS;
	assign want_idx = RW'(want_s1);

	// A variable found in either pool keeps its register; the integer pool is checked first.
	assign held     = hv_s1 && (stat[0].var_hit || stat[1].var_hit);
	assign held_reg = stat[0].var_hit ? var_reg[0] : var_reg[1];

	always_comb begin
		low_idx = '0;
		for (int k = NUM_REGS - 1; k >= 0; k--) begin
			if (!sb[k]) begin
				low_idx = RW'(k);
			end
		end
	end

	assign any_free  = !(&sb);
	assign want_free = wv_s1 && want_ok && !sb[want_idx];
	assign regno     = want_free ? want_idx : low_idx;
	assign evict     = !any_free && ss.has_owner;
	assign err       = !any_free && !ss.has_owner;
	assign grant     = held ? held_reg : (any_free ? regno : head_reg[cls_s1]);

	always_comb begin
		cmd_sel     = '0;
		tgt         = want_idx;
		res_reg     = '0;
		res_valid   = 1'b0;
		res_held    = 1'b0;
		res_spilled = 1'b0;
		res_err     = 1'b0;
		unique case (op_s1)
			rafs_pkg::OP_ALLOC: begin
				if (held) begin
					res_reg   = RegW'(grant);
					res_valid = 1'b1;
					res_held  = 1'b1;
				end else if (err) begin
					res_err = 1'b1;
				end else begin
					// An evicted register stays busy and passes to the new owner.
					cmd_sel.busy_set = any_free;
					cmd_sel.rm_head  = !any_free;
					cmd_sel.append   = hv_s1;
					tgt              = grant;
					res_reg          = RegW'(grant);
					res_valid        = 1'b1;
					res_spilled      = evict;
				end
			end
			rafs_pkg::OP_RESERVE: begin
				if (want_ok) begin
					cmd_sel.rm_reg   = sb[want_idx];
					cmd_sel.busy_set = 1'b1;
				end
			end
			rafs_pkg::OP_FREE_VAR: begin
				if (hv_s1 && ss.var_hit) begin
					cmd_sel.rm_var   = 1'b1;
					cmd_sel.busy_clr = 1'b1;
					tgt              = var_reg[cls_s1];
				end
			end
			rafs_pkg::OP_FREE_REG: begin
				if (want_ok) begin
					cmd_sel.rm_reg   = 1'b1;
					cmd_sel.busy_clr = 1'b1;
				end
			end
			default: begin
				cmd_sel = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= adv || (rsp_valid_q && !rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			reg_res_q     <= res_reg;
			reg_valid_q   <= res_valid;
			held_q        <= res_held;
			spilled_q     <= res_spilled;
			spilled_var_q <= res_spilled ? VarW'(head_var[cls_s1]) : '0;
			error_q       <= res_err;
			used_mask_q   <= MaskW'(used_nxt[cls_s1]);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.reg_res      = reg_res_q;
	assign rsp.reg_valid    = reg_valid_q;
	assign rsp.already_held = held_q;
	assign rsp.spilled      = spilled_q;
	assign rsp.spilled_var  = spilled_var_q;
	assign rsp.error        = error_q;
	assign rsp.used_mask    = used_mask_q;

endmodule

`default_nettype wire

### src/rafs_pool.sv
// One register pool: busy and used masks plus the age-ordered owner list.
// Matches owners by variable and by register, compacts on removal, appends at the tail.
// Depends on rafs_pkg for the command and status structs.
`default_nettype none

module rafs_pool #(
	parameter int NUM_REGS    = rafs_pkg::NUM_REGS_DEF,
	parameter int VAR_ID_BITS = rafs_pkg::VAR_ID_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [VAR_ID_BITS-1:0]   qvar,
	input  wire logic [$clog2(NUM_REGS)-1:0] qreg,
	input  wire logic [$clog2(NUM_REGS)-1:0] tgt,
	input  wire rafs_pkg::pool_cmd_t      cmd,
	output logic [NUM_REGS-1:0]           busy,
	output logic [NUM_REGS-1:0]           used_nxt,
	output rafs_pkg::pool_stat_t          stat,
	output logic [$clog2(NUM_REGS)-1:0]   var_reg,
	output logic [$clog2(NUM_REGS)-1:0]   head_reg,
	output logic [VAR_ID_BITS-1:0]        head_var
);

	localparam int RW = $clog2(NUM_REGS);
	localparam int CW = $clog2(NUM_REGS + 1);

	logic [NUM_REGS-1:0]    busy_q, used_q;
	logic [CW-1:0]          count_q;
	logic [VAR_ID_BITS-1:0] own_var_q [NUM_REGS];
	logic [RW-1:0]          own_reg_q [NUM_REGS];
	logic [VAR_ID_BITS-1:0] own_var_nxt [NUM_REGS];
	logic [RW-1:0]          own_reg_nxt [NUM_REGS];

	logic          var_hit, reg_hit;
	logic [RW-1:0] var_pos, reg_pos, rm_pos;
	logic          rm_any, app_ok;
	logic [CW-1:0] count_mid;
	logic [NUM_REGS-1:0] tmask;

	// Owner lookups: the oldest matching live entry wins.
	always_comb begin
		var_hit = 1'b0;
		var_pos = '0;
		reg_hit = 1'b0;
		reg_pos = '0;
		for (int i = NUM_REGS - 1; i >= 0; i--) begin
			if (CW'(i) < count_q && own_var_q[i] == qvar) begin
				var_hit = 1'b1;
				var_pos = RW'(i);
			end
			if (CW'(i) < count_q && own_reg_q[i] == qreg) begin
				reg_hit = 1'b1;
				reg_pos = RW'(i);
			end
		end
	end

	always_comb begin
		rm_pos = '0;
		if (cmd.rm_var) begin
			rm_pos = var_pos;
		end else if (cmd.rm_reg) begin
			rm_pos = reg_pos;
		end
		rm_any = (cmd.rm_var && var_hit) || (cmd.rm_reg && reg_hit)
			|| (cmd.rm_head && count_q != '0);
		count_mid = count_q - CW'(rm_any);
		app_ok = cmd.append && (count_mid < CW'(NUM_REGS));
	end

	// Each entry either keeps its value, takes its younger neighbor when it or an older
	// entry is removed, or receives the appended owner at the new tail.
	for (genvar g = 0; g < NUM_REGS; g++) begin : g_entry
		logic [VAR_ID_BITS-1:0] up_var;
		logic [RW-1:0]          up_reg;
		if (g < NUM_REGS - 1) begin : g_mid
			assign up_var = own_var_q[g+1];
			assign up_reg = own_reg_q[g+1];
		end else begin : g_last
			assign up_var = own_var_q[g];
			assign up_reg = own_reg_q[g];
		end

		always_comb begin
			own_var_nxt[g] = own_var_q[g];
			own_reg_nxt[g] = own_reg_q[g];
			if (rm_any && RW'(g) >= rm_pos) begin
				own_var_nxt[g] = up_var;
				own_reg_nxt[g] = up_reg;
			end
			if (app_ok && CW'(g) == count_mid) begin
				own_var_nxt[g] = qvar;
				own_reg_nxt[g] = tgt;
			end
		end
	end

	assign tmask    = NUM_REGS'(1) << tgt;
	assign used_nxt = used_q | (cmd.busy_set ? tmask : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			used_q  <= '0;
			count_q <= '0;
		end else begin
			busy_q  <= (busy_q & ~(cmd.busy_clr ? tmask : '0)) | (cmd.busy_set ? tmask : '0);
			used_q  <= used_nxt;
			count_q <= count_mid + CW'(app_ok);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_REGS; i++) begin
			own_var_q[i] <= own_var_nxt[i];
			own_reg_q[i] <= own_reg_nxt[i];
		end
	end

	assign busy           = busy_q;
	assign stat.var_hit   = var_hit;
	assign stat.has_owner = (count_q != '0);
	assign var_reg        = own_reg_q[var_pos];
	assign head_reg       = own_reg_q[0];
	assign head_var       = own_var_q[0];

endmodule

`default_nettype wire
